>>> src/mlcc_pkg.sv
// Shared constants, item widths and helpers for the meter line checksum checker.
// No dependencies; imported by the channel interfaces and the top level.
package mlcc_pkg;

  localparam int unsigned RX_BYTE_W  = 8;
  localparam int unsigned LINE_LEN_W = 8;

  localparam logic [RX_BYTE_W-1:0]  CHAR_CR    = 8'h0D;
  localparam logic [RX_BYTE_W-1:0]  CHAR_SPACE = 8'h20;
  localparam logic [LINE_LEN_W-1:0] LEN_MAX    = 8'hFF;
  localparam logic [5:0]            SUM_SPACE  = 6'h20;

  typedef logic [5:0] sum_t;

  function automatic logic starts_line(input logic [RX_BYTE_W-1:0] b);
    starts_line = ((b >= 8'h41) && (b <= 8'h5A)) ||
                  ((b >= 8'h30) && (b <= 8'h39)) ||
                  (b == CHAR_SPACE);
  endfunction

  function automatic logic [RX_BYTE_W-1:0] expected_char(input sum_t sum);
    sum_t folded;
    folded = sum - SUM_SPACE;
    expected_char = {2'b00, folded} + CHAR_SPACE;
  endfunction

endpackage

>>> src/mlcc_in_if.sv
// Byte input channel: valid/ready handshake carrying one received meter byte.
// Depends on mlcc_pkg for the byte width.
interface mlcc_in_if
  import mlcc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [RX_BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> src/mlcc_out_if.sv
// Line result channel: valid/ready handshake carrying validity and line length.
// Depends on mlcc_pkg for the length width.
interface mlcc_out_if
  import mlcc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  line_valid;
  logic [LINE_LEN_W-1:0] line_length;

  modport source (output valid, output line_valid, output line_length, input ready);
  modport sink   (input valid, input line_valid, input line_length, output ready);
endinterface

>>> src/meter_line_checksum_checker.sv
// Meter line checksum checker: frames meter lines and checks their checksum character.
// Depends on mlcc_pkg, mlcc_in_if and mlcc_out_if.
//
// Usage:
//   in_i carries one received byte per item. Lines end with carriage return.
//   out_o carries one item per carriage return: line_valid and line_length.
//   Other bytes produce no item; a line that fills LINE_BUFFER_BYTES without a
//   carriage return is dropped without an item and the line state restarts.
// Timing:
//   A byte is held in an input register; when it is consumed, the line state
//   and the result register update from it, so a carriage return's result is
//   registered there. One byte per cycle is sustained while out_o takes its
//   results; the single input register and result register set that figure.
// Reset:
//   rst_ni clears the line state and the valid flags of both stages; the next byte that can start a line begins one.
// Stalls:
//   While out_o.ready is low a pending result holds, the input register stops
//   advancing and in_i.ready drops once it is occupied.
module meter_line_checksum_checker
  import mlcc_pkg::*;
#(
  parameter int unsigned LINE_BUFFER_BYTES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mlcc_in_if.sink      in_i,
  mlcc_out_if.source   out_o
);

  localparam int unsigned FILL_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_BUFFER_BYTES - 1);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SUM,
    PH_DECIDED
  } phase_e;

  logic                  in_vld_q;
  logic [RX_BYTE_W-1:0]  in_byte_q;
  logic                  fire;

  phase_e                phase_q, phase_d;
  logic [1:0]            space_q, space_d;
  sum_t                  sum_q, sum_d;
  logic                  verdict_q, verdict_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [LINE_LEN_W-1:0] kept_q, kept_d;

  logic                  out_vld_q, out_vld_d;
  logic                  out_valid_q, out_valid_d;
  logic [LINE_LEN_W-1:0] out_len_q, out_len_d;

  assign fire       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || fire;

  always_comb begin
    phase_d     = phase_q;
    space_d     = space_q;
    sum_d       = sum_q;
    verdict_d   = verdict_q;
    fill_d      = fill_q;
    kept_d      = kept_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_valid_d = out_valid_q;
    out_len_d   = out_len_q;
    if (fire) begin
      if (in_byte_q == CHAR_CR) begin
        out_vld_d   = 1'b1;
        out_valid_d = verdict_q;
        out_len_d   = kept_q;
        phase_d     = PH_SKIP;
        space_d     = '0;
        sum_d       = '0;
        verdict_d   = 1'b0;
        fill_d      = '0;
        kept_d      = '0;
      end else if (fill_q == FILL_MAX) begin
        phase_d   = PH_SKIP;
        space_d   = '0;
        sum_d     = '0;
        verdict_d = 1'b0;
        fill_d    = '0;
        kept_d    = '0;
      end else begin
        fill_d = fill_q + 1'b1;
        if (phase_q != PH_SKIP || starts_line(in_byte_q)) begin
          if (kept_q != LEN_MAX) begin
            kept_d = kept_q + 1'b1;
          end
          if (phase_q != PH_DECIDED) begin
            phase_d = PH_SUM;
            if (in_byte_q != CHAR_SPACE && space_q == 2'd2) begin
              verdict_d = (expected_char(sum_q) == in_byte_q);
              phase_d   = PH_DECIDED;
            end else begin
              if (in_byte_q == CHAR_SPACE && space_q != 2'd3) begin
                space_d = space_q + 1'b1;
              end
              sum_d = sum_q + in_byte_q[5:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      phase_q   <= PH_SKIP;
      space_q   <= '0;
      sum_q     <= '0;
      verdict_q <= 1'b0;
      fill_q    <= '0;
      kept_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      phase_q   <= phase_d;
      space_q   <= space_d;
      sum_q     <= sum_d;
      verdict_q <= verdict_d;
      fill_q    <= fill_d;
      kept_q    <= kept_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.rx_byte;
    end
    out_valid_q <= out_valid_d;
    out_len_q   <= out_len_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.line_valid  = out_valid_q;
  assign out_o.line_length = out_len_q;

  a_cr_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_byte_q == CHAR_CR) |=> out_vld_q)
    else $error("carriage return did not load a result");

  a_result_from_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(fire && (in_byte_q == CHAR_CR)))
    else $error("result raised without a carriage return");

  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (kept_q == '0 && sum_q == '0 && space_q == '0))
    else $error("line state dirty while skipping");

  a_verdict_decided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_q |-> (phase_q == PH_DECIDED))
    else $error("verdict set before decision");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("fill count beyond buffer");

endmodule
